// ----- rtl/xdse_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xdse_pkg
// Shared types and constants of the X-drop seed extension unit.
// ----------------------------------------------------------------------------
package xdse_pkg;

  localparam int ScoreW = 22;
  localparam logic [19:0] ScoreMax = 20'hFFFFF;
  localparam int MaxLen = 32768;

  typedef enum logic [1:0] {
    KIND_LOAD_Q = 2'd0,
    KIND_LOAD_T = 2'd1,
    KIND_START  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    CFG_MATCH = 3'd0,
    CFG_MISMATCH = 3'd1,
    CFG_GAP = 3'd2,
    CFG_XDROP = 3'd3,
    CFG_SEED = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [3:0] mat;
    logic signed [4:0] mis;
    logic signed [4:0] gap;
    logic [9:0] xd;
  } score_cfg_t;

endpackage

// ----- rtl/xdse_cell_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xdse_cell_unit
// Shared cell unit: best of three moves, then X-drop prune against best.
// ----------------------------------------------------------------------------
module xdse_cell_unit import xdse_pkg::*; (
  input  score_cfg_t               cfg_i,
  input  logic                     up_ok_i,
  input  logic signed [ScoreW-1:0] up_i,
  input  logic                     lf_ok_i,
  input  logic signed [ScoreW-1:0] lf_i,
  input  logic                     dg_ok_i,
  input  logic signed [ScoreW-1:0] dg_i,
  input  logic                     eq_i,
  input  logic signed [ScoreW-1:0] best_i,
  output logic                     ok_o,
  output logic signed [ScoreW-1:0] v_o
);
  logic signed [ScoreW-1:0] gap, sub, a, b, c, v;
  logic ok;
  always_comb begin
    gap = ScoreW'(cfg_i.gap);
    sub = eq_i ? ScoreW'($signed({1'b0, cfg_i.mat})) : ScoreW'(cfg_i.mis);
    a = up_i + gap;
    b = lf_i + gap;
    c = dg_i + sub;
    v = a;
    ok = up_ok_i;
    if (lf_ok_i && (!ok || b > v)) begin
      v = b;
      ok = 1'b1;
    end
    if (dg_ok_i && (!ok || c > v)) begin
      v = c;
      ok = 1'b1;
    end
    if (ok && v < best_i - ScoreW'($signed({1'b0, cfg_i.xd}))) ok = 1'b0;
    ok_o = ok;
    v_o = v;
  end
endmodule

// ----- rtl/xdse_extend_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xdse_extend_seq
// One extension: walks anti-diagonals cell by cell over three rotating
// buffers, reading bases from the stores and driving the shared cell unit.
// ----------------------------------------------------------------------------
module xdse_extend_seq import xdse_pkg::*; #(
  parameter int AW = 15
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  score_cfg_t               cfg_i,
  input  logic                     go_i,
  input  logic                     left_i,
  input  logic signed [AW+2:0]     qs_i,
  input  logic signed [AW+2:0]     ts_i,
  input  logic signed [AW+2:0]     m_i,
  input  logic signed [AW+2:0]     n_i,
  output logic                     rd_o,
  output logic [AW-1:0]            qa_o,
  output logic [AW-1:0]            ta_o,
  output logic                     qz_o,
  output logic                     tz_o,
  input  logic [7:0]               qb_i,
  input  logic [7:0]               tb_i,
  output logic                     done_o,
  output logic signed [ScoreW-1:0] best_o,
  output logic signed [AW+2:0]     qe_o,
  output logic signed [AW+2:0]     te_o
);
  localparam int Depth = (1 << AW) + 1;
  localparam int IW = AW + 3;
  localparam int BW = ScoreW + 1;
  typedef logic signed [IW-1:0] idx_t;

  typedef enum logic [2:0] {S_IDLE, S_DIAG, S_RD, S_CELL, S_END} state_e;
  state_e state_q;

  logic [BW-1:0] mem0 [Depth];
  logic [BW-1:0] mem1 [Depth];
  logic [BW-1:0] mem2 [Depth];
  logic [1:0] p1_q, p2_q, p3_q;  // two back, one back, current
  logic [BW-1:0] r0_q, r1_q, r2_q;
  logic [BW-1:0] up_q, lf_q, dg_q;
  idx_t rdaddr, wraddr;
  logic [BW-1:0] wrdata;
  logic [1:0] wrsel;
  logic we;

  idx_t l_q, u_q, k_q, lp_q, up2_q, ln_q, un_q, i_q, tri_q, trj_q, m_q, n_q;
  logic signed [ScoreW-1:0] best_q, cb_q;
  logic any_q, hp_q, left_q;
  idx_t qs_q, ts_q;

  logic c_ok;
  logic signed [ScoreW-1:0] c_v;
  logic up_ok, lf_ok, dg_ok;
  idx_t j, qa, ta, ln_nx, un_nx;

  always_comb begin
    j = k_q - i_q;
    up_ok = (i_q < u_q) && up_q[BW-1];
    lf_ok = (i_q >= 1) && (i_q - 1 >= l_q) && lf_q[BW-1];
    dg_ok = hp_q && (i_q >= 1) && (lp_q <= i_q - 1) && (i_q - 1 < up2_q) && dg_q[BW-1];
    if (left_q) begin
      qa = qs_q - i_q + 1;
      ta = ts_q - j + 1;
    end else begin
      qa = qs_q + i_q - 1;
      ta = ts_q + j - 1;
    end
    ln_nx = (l_q < k_q + 1 - n_q) ? k_q + 1 - n_q : l_q;
    un_nx = (u_q > m_q) ? m_q : u_q;
  end
  assign qa_o = qa[AW-1:0];
  assign ta_o = ta[AW-1:0];
  assign qz_o = (qa < 0) || (qa >= idx_t'(1 << AW));
  assign tz_o = (ta < 0) || (ta >= idx_t'(1 << AW));
  assign rd_o = (state_q == S_RD);

  xdse_cell_unit u_cell (
    .cfg_i(cfg_i), .up_ok_i(up_ok), .up_i(up_q[ScoreW-1:0]),
    .lf_ok_i(lf_ok), .lf_i(lf_q[ScoreW-1:0]),
    .dg_ok_i(dg_ok), .dg_i(dg_q[ScoreW-1:0]),
    .eq_i(qb_i == tb_i), .best_i(best_q), .ok_o(c_ok), .v_o(c_v)
  );

  // buffer reads: one-back at i, then one-back and two-back at i-1
  logic [1:0] rphase_q;
  always_ff @(posedge clk_i) begin
    r0_q <= mem0[rdaddr[AW:0]];
    r1_q <= mem1[rdaddr[AW:0]];
    r2_q <= mem2[rdaddr[AW:0]];
    if (we) begin
      if (wrsel == 2'd0) mem0[wraddr[AW:0]] <= wrdata;
      if (wrsel == 2'd1) mem1[wraddr[AW:0]] <= wrdata;
      if (wrsel == 2'd2) mem2[wraddr[AW:0]] <= wrdata;
    end
  end

  function automatic logic [BW-1:0] pick(logic [1:0] s, logic [BW-1:0] a,
                                         logic [BW-1:0] b, logic [BW-1:0] c);
    case (s)
      2'd0: pick = a;
      2'd1: pick = b;
      default: pick = c;
    endcase
  endfunction

  always_comb begin
    we = 1'b0;
    wrsel = p3_q;
    wraddr = i_q;
    wrdata = {c_ok, c_ok ? c_v : ScoreW'(0)};
    rdaddr = i_q;
    if (state_q == S_RD) begin
      case (rphase_q)
        2'd0: rdaddr = i_q;
        default: rdaddr = (i_q >= 1) ? i_q - 1 : idx_t'(0);
      endcase
    end
    if (state_q == S_CELL) we = 1'b1;
    if (state_q == S_IDLE && go_i) begin
      we = 1'b1;
      wrsel = 2'd1;
      wraddr = '0;
      wrdata = {1'b1, ScoreW'(0)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_o <= 1'b0;
      rphase_q <= '0;
      p1_q <= 2'd0; p2_q <= 2'd1; p3_q <= 2'd2;
    end else begin
      done_o <= 1'b0;
      case (state_q)
        S_IDLE: if (go_i) begin
          left_q <= left_i; qs_q <= qs_i; ts_q <= ts_i; m_q <= m_i; n_q <= n_i;
          best_q <= '0; l_q <= '0; u_q <= 1; k_q <= '0; lp_q <= '0; up2_q <= '0;
          tri_q <= '0; trj_q <= '0; hp_q <= 1'b0;
          p1_q <= 2'd0; p2_q <= 2'd1; p3_q <= 2'd2;
          state_q <= S_DIAG;
        end
        S_DIAG: begin
          k_q <= k_q + 1;
          l_q <= ln_nx;
          u_q <= un_nx;
          i_q <= ln_nx;
          any_q <= 1'b0;
          rphase_q <= '0;
          state_q <= (ln_nx <= un_nx) ? S_RD : S_END;
        end
        S_RD: begin
          rphase_q <= rphase_q + 1;
          if (rphase_q == 2'd1) up_q <= pick(p2_q, r0_q, r1_q, r2_q);
          if (rphase_q == 2'd2) begin
            lf_q <= pick(p2_q, r0_q, r1_q, r2_q);
            dg_q <= pick(p1_q, r0_q, r1_q, r2_q);
            state_q <= S_CELL;
          end
        end
        S_CELL: begin
          if (c_ok) begin
            if (c_v > best_q) begin
              tri_q <= i_q;
              trj_q <= j;
            end
            if (!any_q) begin
              ln_q <= i_q;
              cb_q <= c_v;
              any_q <= 1'b1;
            end else if (c_v > cb_q) cb_q <= c_v;
            un_q <= i_q + 1;
          end
          rphase_q <= '0;
          if (i_q < u_q) begin
            i_q <= i_q + 1;
            state_q <= S_RD;
          end else if (!(any_q || c_ok)) begin
            state_q <= S_END;
          end else begin
            if (c_ok && !any_q) begin
              if (c_v > best_q) best_q <= c_v;
            end else if (c_ok && c_v > cb_q) begin
              if (c_v > best_q) best_q <= c_v;
            end else if (cb_q > best_q) best_q <= cb_q;
            hp_q <= 1'b1;
            lp_q <= l_q;
            up2_q <= u_q;
            l_q <= (c_ok && !any_q) ? i_q : ln_q;
            u_q <= c_ok ? i_q + 1 : un_q;
            p1_q <= p2_q; p2_q <= p3_q; p3_q <= p1_q;
            state_q <= S_DIAG;
          end
        end
        S_END: begin
          done_o <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign best_o = best_q;
  assign qe_o = left_q ? qs_q - tri_q + 1 : qs_q + tri_q - 1;
  assign te_o = left_q ? ts_q - trj_q + 1 : ts_q + trj_q - 1;
endmodule

// ----- rtl/xdrop_seed_extension_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xdrop_seed_extension_unit
// X-drop seed extension, right then left, linear gap scoring.
// ----------------------------------------------------------------------------
// channel | dir | handshake         | payload
// in      | in  | in_valid/in_stall | kind, base, index, lengths, seed positions
// out     | out | out_valid/out_stall | total_score, four coordinates
// cfg     | in  | cfg_we_i          | cfg_idx_i, cfg_data_i
// A load item writes its base into the store as it is taken. A start item
// walks each anti-diagonal cell with three buffer reads plus one cell step
// of the shared cell unit, over both extensions, with a sequencing step per
// anti-diagonal; the unit takes no new item until its result is sent.
// Reset clears control only; stores are undefined until written.
// While a result waits under stall no new item is taken.
// ----------------------------------------------------------------------------
module xdrop_seed_extension_unit import xdse_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  base_i,
  input  logic [14:0] index_i,
  input  logic [15:0] query_length_i,
  input  logic [15:0] target_length_i,
  input  logic [14:0] query_seed_pos_i,
  input  logic [14:0] target_seed_pos_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [19:0] total_score_o,
  output logic [14:0] query_left_o,
  output logic [14:0] query_right_o,
  output logic [14:0] target_left_o,
  output logic [14:0] target_right_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [9:0]  cfg_data_i
);
  localparam int AW = $clog2(MaxLen);
  localparam int IW = AW + 3;
  typedef logic signed [IW-1:0] idx_t;
  typedef enum logic [2:0] {T_IDLE, T_RIGHT, T_RWAIT, T_LEFT, T_LWAIT, T_SUM, T_OUT} state_e;

  score_cfg_t cfg_q;
  logic [7:0] seed_q;
  state_e state_q;
  logic [7:0] qmem [MaxLen];
  logic [7:0] tmem [MaxLen];
  logic [7:0] qrd_q, trd_q;
  logic qz_q, tz_q;

  idx_t ql_q, tl_q, qb_q, tb_q, qel_q, qer_q, tel_q, ter_q;
  logic signed [ScoreW+1:0] tot_q;
  logic go, left;
  idx_t qs, ts, m, n, qe, te;
  logic rd, qz, tz, done;
  logic [AW-1:0] qa, ta;
  logic signed [ScoreW-1:0] best;
  logic accept;

  assign in_stall = (state_q != T_IDLE);
  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{mat: 4'd1, mis: -5'sd1, gap: -5'sd1, xd: 10'd15};
      seed_q <= 8'd31;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MATCH: cfg_q.mat <= cfg_data_i[3:0];
        CFG_MISMATCH: cfg_q.mis <= cfg_data_i[4:0];
        CFG_GAP: cfg_q.gap <= cfg_data_i[4:0];
        CFG_XDROP: cfg_q.xd <= cfg_data_i;
        CFG_SEED: seed_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && kind_i == KIND_LOAD_Q && {1'b0, index_i} < 16'(MaxLen))
      qmem[index_i[AW-1:0]] <= base_i;
    if (accept && kind_i == KIND_LOAD_T && {1'b0, index_i} < 16'(MaxLen))
      tmem[index_i[AW-1:0]] <= base_i;
    if (rd) begin
      qrd_q <= qmem[qa];
      trd_q <= tmem[ta];
      qz_q <= qz;
      tz_q <= tz;
    end
  end

  xdse_extend_seq #(.AW(AW)) u_ext (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_i(cfg_q), .go_i(go), .left_i(left),
    .qs_i(qs), .ts_i(ts), .m_i(m), .n_i(n), .rd_o(rd), .qa_o(qa), .ta_o(ta),
    .qz_o(qz), .tz_o(tz), .qb_i(qz_q ? 8'd0 : qrd_q), .tb_i(tz_q ? 8'd0 : trd_q),
    .done_o(done), .best_o(best), .qe_o(qe), .te_o(te)
  );

  idx_t sl;
  logic outside, no_r, no_l;
  always_comb begin
    sl = idx_t'(seed_q);
    outside = (qb_q >= ql_q) || (tb_q >= tl_q);
    no_r = outside || (qb_q + sl >= ql_q) || (tb_q + sl >= tl_q);
    no_l = outside || (qb_q == 0) || (tb_q == 0);
    go = (state_q == T_RIGHT && !no_r) || (state_q == T_LEFT && !no_l);
    left = (state_q == T_LEFT);
    qs = left ? qb_q - 1 : qb_q + sl;
    ts = left ? tb_q - 1 : tb_q + sl;
    m = left ? qb_q : ql_q - qb_q - sl;
    n = left ? tb_q : tl_q - tb_q - sl;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state_q)
        T_IDLE: if (accept && kind_i == KIND_START) begin
          ql_q <= (query_length_i > 16'(MaxLen)) ? idx_t'(MaxLen) : idx_t'(query_length_i);
          tl_q <= (target_length_i > 16'(MaxLen)) ? idx_t'(MaxLen) : idx_t'(target_length_i);
          qb_q <= idx_t'(query_seed_pos_i);
          tb_q <= idx_t'(target_seed_pos_i);
          tot_q <= '0;
          state_q <= T_RIGHT;
        end
        T_RIGHT: begin
          qer_q <= qb_q + sl - 1;
          ter_q <= tb_q + sl - 1;
          state_q <= no_r ? T_LEFT : T_RWAIT;
        end
        T_RWAIT: if (done) begin
          qer_q <= qe;
          ter_q <= te;
          tot_q <= (ScoreW+2)'(best);
          state_q <= T_LEFT;
        end
        T_LEFT: begin
          qel_q <= qb_q;
          tel_q <= tb_q;
          state_q <= no_l ? T_SUM : T_LWAIT;
        end
        T_LWAIT: if (done) begin
          qel_q <= qe;
          tel_q <= te;
          tot_q <= tot_q + (ScoreW+2)'(best);
          state_q <= T_SUM;
        end
        T_SUM: begin
          tot_q <= tot_q + (ScoreW+2)'($signed({1'b0, 12'(cfg_q.mat) * 12'(seed_q)}));
          state_q <= T_OUT;
          out_valid <= 1'b0;
        end
        T_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            total_score_o <= (tot_q < 0) ? 20'd0 :
              (tot_q > (ScoreW+2)'(ScoreMax)) ? ScoreMax : tot_q[19:0];
            query_left_o <= qel_q[14:0];
            query_right_o <= qer_q[14:0];
            target_left_o <= tel_q[14:0];
            target_right_o <= ter_q[14:0];
          end else if (!out_stall) begin
            out_valid <= 1'b0;
            state_q <= T_IDLE;
          end
        end
        default: state_q <= T_IDLE;
      endcase
    end
  end
endmodule

// ----- rtl/xdse_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xdse_checker
// Port-level checks on the seed extension unit.
// ----------------------------------------------------------------------------
module xdse_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [19:0] total_score_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid && $stable(total_score_o))
    else $error("result dropped under stall");
  a_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> in_stall) else $error("input taken while result pending");
  a_out_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_stall |=> !out_valid) else $error("result repeated");
endmodule

bind xdrop_seed_extension_unit xdse_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .total_score_o(total_score_o)
);

// ----- tb/sv/xdrop_seed_extension_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xdrop_seed_extension_unit_tb
// Self-checking bench: base loads and seed starts are driven with random
// gaps and output stalls; an in-bench X-drop predictor gives each result.
// ----------------------------------------------------------------------------
module xdrop_seed_extension_unit_tb;
  import xdse_pkg::*;

  localparam int CapLen = 32768;
  localparam int Region = 64;
  localparam int CycLimit = 60000000;

  typedef struct packed {
    logic [19:0] score;
    logic [14:0] q_lo, q_hi, t_lo, t_hi;
  } ext_res_t;

  class ext_scoreboard;
    byte unsigned qmem[CapLen];
    byte unsigned tmem[CapLen];
    int cs[3][Region+2];
    bit cv[3][Region+2];
    int mat, mis, gap, xd, sl;
    ext_res_t exp_q[$];
    int errors, results;

    function new();
      mat = 1; mis = -1; gap = -1; xd = 15; sl = 31;
    endfunction

    function void configure(cfg_idx_e idx, logic [9:0] d);
      case (idx)
        CFG_MATCH:    mat = d[3:0];
        CFG_MISMATCH: mis = int'($signed(d[4:0]));
        CFG_GAP:      gap = int'($signed(d[4:0]));
        CFG_XDROP:    xd  = d;
        CFG_SEED:     sl  = d[7:0];
        default: ;
      endcase
    endfunction

    function int base_at(bit tgt, int pos);
      if (pos < 0 || pos >= CapLen) return 0;
      return tgt ? tmem[pos] : qmem[pos];
    endfunction

    function int walk(bit left, int qs, int ts, int m, int n, output int qe, output int te);
      int best, lo, hi, k, plo, phi, bi, bj, i, j, v, c, cb, nlo, nhi, p1, p2, p3, t;
      int qa, ta;
      bit ok, any, hp;
      best = 0; lo = 0; hi = 1; k = 0; plo = 0; phi = 0; bi = 0; bj = 0; hp = 0;
      p1 = 0; p2 = 1; p3 = 2;
      cs[p2][0] = 0; cv[p2][0] = 1;
      forever begin
        any = 0; cb = 0; nlo = 0; nhi = 0;
        k++;
        if (lo < k - n) lo = k - n;
        if (hi > m) hi = m;
        for (i = lo; i <= hi; i++) begin
          j = k - i; v = 0; ok = 0;
          if (i < hi && cv[p2][i]) begin v = cs[p2][i] + gap; ok = 1; end
          if (i >= 1 && i - 1 >= lo && cv[p2][i-1]) begin
            c = cs[p2][i-1] + gap;
            if (!ok || c > v) v = c;
            ok = 1;
          end
          if (hp && i >= 1 && plo <= i - 1 && i - 1 < phi && cv[p1][i-1]) begin
            if (left) begin qa = base_at(0, qs - i + 1); ta = base_at(1, ts - j + 1); end
            else begin qa = base_at(0, qs + i - 1); ta = base_at(1, ts + j - 1); end
            c = cs[p1][i-1] + (qa == ta ? mat : mis);
            if (!ok || c > v) v = c;
            ok = 1;
          end
          if (ok && v < best - xd) ok = 0;
          if (ok) begin
            if (v > best) begin bi = i; bj = j; end
            if (!any) begin nlo = i; cb = v; any = 1; end
            if (v > cb) cb = v;
            nhi = i + 1;
          end
          cs[p3][i] = ok ? v : 0;
          cv[p3][i] = ok;
        end
        if (!any) break;
        if (cb > best) best = cb;
        hp = 1; plo = lo; phi = hi; lo = nlo; hi = nhi;
        t = p1; p1 = p2; p2 = p3; p3 = t;
      end
      qe = left ? qs - bi + 1 : qs + bi - 1;
      te = left ? ts - bj + 1 : ts + bj - 1;
      return best;
    endfunction

    // stimulus keeps every base read inside the loaded region
    function bit reads_safe(int qlen, int tlen, int qb, int tb);
      int ql, tl;
      ql = qlen > CapLen ? CapLen : qlen;
      tl = tlen > CapLen ? CapLen : tlen;
      if (qb >= ql || tb >= tl) return 1;
      if (!(qb + sl >= ql || tb + sl >= tl) && (ql > Region || tl > Region)) return 0;
      if (qb > 0 && tb > 0 && (qb > Region || tb > Region)) return 0;
      return 1;
    endfunction

    function void note_item(kind_e kind, int base, int idx, int qlen, int tlen,
                            int qb, int tb);
      int ql, tl, qel, qer, tel, ter;
      longint rs, ls, tot;
      bit outside;
      ext_res_t r;
      rs = 0; ls = 0;
      case (kind)
        KIND_LOAD_Q: qmem[idx] = base;
        KIND_LOAD_T: tmem[idx] = base;
        KIND_START: begin
          ql = qlen > CapLen ? CapLen : qlen;
          tl = tlen > CapLen ? CapLen : tlen;
          outside = (qb >= ql) || (tb >= tl);
          if (outside || qb + sl >= ql || tb + sl >= tl) begin
            qer = qb + sl - 1; ter = tb + sl - 1;
          end else begin
            rs = walk(0, qb + sl, tb + sl, ql - qb - sl, tl - tb - sl, qer, ter);
          end
          if (outside || qb <= 0 || tb <= 0) begin
            qel = qb; tel = tb;
          end else begin
            ls = walk(1, qb - 1, tb - 1, qb, tb, qel, tel);
          end
          tot = rs + ls + longint'(mat) * sl;
          if (tot > ScoreMax) tot = ScoreMax;
          if (tot < 0) tot = 0;
          r.score = tot[19:0];
          r.q_lo = qel[14:0]; r.q_hi = qer[14:0];
          r.t_lo = tel[14:0]; r.t_hi = ter[14:0];
          exp_q = {exp_q, r};
        end
        default: ;
      endcase
    endfunction

    function void check_result(ext_res_t got);
      ext_res_t e;
      results++;
      if (exp_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result score=%0d", got.score);
        return;
      end
      e = exp_q.pop_front();
      if (got !== e) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: exp score=%0d q=%0d..%0d t=%0d..%0d",
                   e.score, e.q_lo, e.q_hi, e.t_lo, e.t_hi);
          $display("          got score=%0d q=%0d..%0d t=%0d..%0d",
                   got.score, got.q_lo, got.q_hi, got.t_lo, got.t_hi);
        end
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  kind_i = 0;
  logic [7:0]  base_i = 0;
  logic [14:0] index_i = 0;
  logic [15:0] query_length_i = 0;
  logic [15:0] target_length_i = 0;
  logic [14:0] query_seed_pos_i = 0;
  logic [14:0] target_seed_pos_i = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [19:0] total_score_o;
  logic [14:0] query_left_o, query_right_o, target_left_o, target_right_o;
  logic        cfg_we_i = 0;
  logic [2:0]  cfg_idx_i = 0;
  logic [9:0]  cfg_data_i = 0;

  ext_scoreboard sb = new();
  int  cycles = 0;
  bit  calm = 0;
  int  n_starts = 0, n_loads = 0;

  xdrop_seed_extension_unit i_dut (.*);

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycLimit) begin
      $display("xdrop_seed_extension_unit verification failed");
      $finish;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && out_valid && !out_stall)
      sb.check_result('{total_score_o, query_left_o, query_right_o,
                        target_left_o, target_right_o});

  // receiver back-pressure
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      n = calm ? 0 : $urandom_range(0, 3);
      if (n > 0) begin
        out_stall <= 1;
        repeat (n) @(posedge clk_i);
        out_stall <= 0;
      end
      do @(posedge clk_i); while (!(out_valid && !out_stall));
    end
  end

  // one transfer on the input channel; valid stays up across zero gaps
  task automatic send(kind_e k, int base, int idx, int qlen, int tlen, int qb, int tb);
    int g;
    g = calm ? 0 : $urandom_range(0, 3);
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk_i);
    end
    in_valid <= 1;
    kind_i <= k; base_i <= 8'(base); index_i <= 15'(idx);
    query_length_i <= 16'(qlen); target_length_i <= 16'(tlen);
    query_seed_pos_i <= 15'(qb); target_seed_pos_i <= 15'(tb);
    do @(posedge clk_i); while (in_stall);
    sb.note_item(k, base, idx, qlen, tlen, qb, tb);
    if (k == KIND_START) n_starts++;
    else if (k != KIND_NONE) n_loads++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.exp_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic load_regs(int m, int mi, int g, int x, int s);
    logic [9:0] d[5];
    d[0] = {6'($urandom_range(0, 63)), m[3:0]};
    d[1] = {5'($urandom_range(0, 31)), mi[4:0]};
    d[2] = {5'($urandom_range(0, 31)), g[4:0]};
    d[3] = x[9:0];
    d[4] = {2'($urandom_range(0, 3)), s[7:0]};
    for (int i = 0; i < 5; i++) begin
      cfg_we_i <= 1; cfg_idx_i <= cfg_idx_e'(i); cfg_data_i <= d[i];
      @(posedge clk_i);
      sb.configure(cfg_idx_e'(i), d[i]);
    end
    cfg_we_i <= 0;
    @(posedge clk_i);
  endtask

  task automatic rand_start(int maxlen);
    int ql, tl, qb, tb;
    if ($urandom_range(0, 9) == 0) begin
      ql = $urandom_range(0, 65535); tl = $urandom_range(0, 65535);
      qb = $urandom_range(0, 32767); tb = $urandom_range(0, 32767);
      if ($urandom_range(0, 1)) begin qb = $urandom_range(0, 63); tb = $urandom_range(0, 63); end
      if (!sb.reads_safe(ql, tl, qb, tb)) tl = tb;
    end else begin
      ql = $urandom_range(4, maxlen); tl = $urandom_range(4, maxlen);
      qb = $urandom_range(0, ql - 1);
      tb = qb + $urandom_range(0, 4) - 2;
      if (tb < 0) tb = 0;
      if (tb >= tl) tb = tl - 1;
    end
    send(KIND_START, $urandom_range(0, 255), $urandom_range(0, 32767), ql, tl, qb, tb);
  endtask

  task automatic rand_item();
    int r, idx, b;
    r = $urandom_range(0, 99);
    if (r < 65) rand_start($urandom_range(0, 19) == 0 ? Region : 32);
    else if (r < 90) begin
      idx = $urandom_range(0, Region - 1);
      b = $urandom_range(0, 9) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 3);
      send(r < 78 ? KIND_LOAD_Q : KIND_LOAD_T, b, idx, 0, 0, 0, 0);
    end else if (r < 96)
      send(r[0] ? KIND_LOAD_Q : KIND_LOAD_T, $urandom_range(0, 255),
           $urandom_range(Region, 32767), 0, 0, 0, 0);
    else
      send(KIND_NONE, $urandom_range(0, 255), $urandom_range(0, 32767),
           $urandom_range(0, 65535), $urandom_range(0, 65535),
           $urandom_range(0, 32767), $urandom_range(0, 32767));
  endtask

  initial begin
    byte unsigned qb_seq[Region];
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // field extremes, then a related query/target pair in the low region
    send(KIND_LOAD_Q, 255, 32767, 0, 0, 0, 0);
    send(KIND_LOAD_T, 0, 32767, 65535, 65535, 32767, 32767);
    send(KIND_NONE, 255, 32767, 65535, 65535, 32767, 32767);
    for (int i = 0; i < Region; i++) begin
      qb_seq[i] = $urandom_range(0, 3);
      send(KIND_LOAD_Q, qb_seq[i], i, 0, 0, 0, 0);
      send(KIND_LOAD_T, $urandom_range(0, 9) == 0 ? $urandom_range(0, 255) : qb_seq[i],
           i, 0, 0, 0, 0);
    end
    send(KIND_START, 0, 0, 64, 64, 10, 10);
    send(KIND_START, 0, 0, 64, 64, 40, 40);
    send(KIND_START, 0, 0, 64, 64, 0, 5);
    send(KIND_START, 0, 0, 64, 64, 5, 0);
    send(KIND_START, 0, 0, 65535, 40, 30, 20);
    send(KIND_START, 0, 0, 40, 32768, 20, 30);
    send(KIND_START, 0, 0, 64, 64, 70, 3);
    send(KIND_START, 0, 0, 1, 1, 0, 0);
    send(KIND_START, 0, 0, 64, 64, 32767, 32767);
    drain();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: load_regs(2, -3, -2, 20, 6);
        1: load_regs(15, -15, -15, 1023, 1);
        2: load_regs(1, -1, -1, 0, 255);
        3: load_regs(0, 15, -16, 511, 0);
        4: load_regs($urandom_range(1, 15), -$urandom_range(1, 15), -$urandom_range(1, 15),
                     $urandom_range(0, 60), $urandom_range(1, 10));
        default: load_regs(1, -1, -1, 15, 31);
      endcase
      for (int i = 0; i < 74; i++) begin
        if (i % 30 == 0) calm = (i == 30);
        rand_item();
      end
      calm = 0;
      drain();
    end

    $display("covered %0d starts and %0d base loads over 7 register settings, %0d results",
             n_starts, n_loads, sb.results);
    if (sb.errors == 0 && sb.exp_q.size() == 0)
      $display("xdrop_seed_extension_unit verification clean");
    else
      $display("xdrop_seed_extension_unit verification failed");
    $finish;
  end

endmodule
